[rtl/jms_pkg.sv]
// ----------------------------------------------------------------------------
// jms_pkg
// Shared types and codes of the JPEG marker scanner.
// ----------------------------------------------------------------------------
package jms_pkg;

  localparam int unsigned TDATA_OUT_W = 96;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_APP   = 3'd1,
    EV_BYTE  = 3'd2,
    EV_LAST  = 3'd3,
    EV_FRAME = 3'd4,
    EV_END   = 3'd5,
    EV_ERR   = 3'd6
  } jms_event_t;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_SOI   = 3'd1;
  localparam logic [2:0] ERR_SHORT    = 3'd2;
  localparam logic [2:0] ERR_FRAMELEN = 3'd3;
  localparam logic [2:0] ERR_EARLY    = 3'd4;

  localparam logic [1:0] WARN_NONE     = 2'd0;
  localparam logic [1:0] WARN_SPURIOUS = 2'd1;
  localparam logic [1:0] WARN_NO_SOI   = 2'd2;

  localparam logic [3:0] PROC_NONE    = 4'd13;
  localparam logic [3:0] PROC_NOT_SOF = 4'd14;

  typedef struct packed {
    logic        frame_seen;
    logic [3:0]  process_index;
    logic [7:0]  components;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  precision;
    logic [1:0]  warning;
    logic [2:0]  error_code;
    logic [7:0]  payload_byte;
    logic [15:0] segment_length;
    logic [7:0]  marker;
    jms_event_t  event_res;
  } jms_result_t;

endpackage

[rtl/jms_parser.sv]
// ----------------------------------------------------------------------------
// jms_parser
// Marker state machine: consumes one byte per accepted item and forms its
// result in the same cycle.
// ----------------------------------------------------------------------------
module jms_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                first_of_file,
  input  logic                last_of_file,
  output jms_pkg::jms_result_t res
);
  import jms_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_TOP2, PH_SOI_SEEK, PH_SOI_PAD, PH_SEEK, PH_PAD, PH_LEN_HI,
    PH_LEN_LO, PH_PAYLOAD, PH_SKIP, PH_SOF_P, PH_SOF_H1, PH_SOF_H2,
    PH_SOF_W1, PH_SOF_W2, PH_SOF_N
  } phase_t;

  // Process index of a frame marker, PROC_NOT_SOF for anything else.
  function automatic logic [3:0] sof_index(input logic [7:0] m);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = m[3:0];
    if (m[7:4] != 4'hC || lo == 4'd4 || lo == 4'd8 || lo == 4'd12) begin
      idx = PROC_NOT_SOF;
    end else begin
      idx = lo - {3'd0, lo > 4'd4} - {3'd0, lo > 4'd8} - {3'd0, lo > 4'd12};
    end
    return idx;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] decl_r, decl_nxt;
  logic        spur_r, spur_nxt;
  logic [7:0]  prec_r, prec_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] width_r, width_nxt;
  logic [7:0]  comps_r, comps_nxt;
  logic [3:0]  proc_r, proc_nxt;
  logic        frame_r, frame_nxt;

  jms_event_t  ev;
  logic [2:0]  err;
  logic [1:0]  warn;
  logic [15:0] seglen;
  logic [7:0]  pbyte;
  logic [15:0] len_full;
  logic [15:0] left_dec;
  logic [3:0]  sof_cur;
  logic [10:0] sof_expect;

  assign len_full   = {len_hi_r, data_byte};
  assign left_dec   = left_r - 16'd1;
  assign sof_cur    = sof_index(marker_r);
  assign sof_expect = 11'd6 + 11'd3 * {3'd0, data_byte};

  always_comb begin
    phase_nxt  = phase_r;
    marker_nxt = marker_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    decl_nxt   = decl_r;
    spur_nxt   = spur_r;
    prec_nxt   = prec_r;
    height_nxt = height_r;
    width_nxt  = width_r;
    comps_nxt  = comps_r;
    proc_nxt   = proc_r;
    frame_nxt  = frame_r;
    ev         = EV_NONE;
    err        = ERR_NONE;
    warn       = WARN_NONE;
    seglen     = 16'd0;
    pbyte      = 8'd0;

    if (first_of_file) begin
      spur_nxt = 1'b0;
      if (data_byte == 8'hFF) begin
        phase_nxt = PH_TOP2;
      end else begin
        warn      = WARN_NO_SOI;
        phase_nxt = PH_SOI_SEEK;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_TOP2: begin
          if (data_byte == 8'hD8) begin
            phase_nxt = PH_SEEK;
          end else begin
            warn      = WARN_NO_SOI;
            phase_nxt = PH_SOI_SEEK;
          end
        end
        PH_SOI_SEEK, PH_SEEK: begin
          if (data_byte == 8'hFF) begin
            phase_nxt = (phase_r == PH_SEEK) ? PH_PAD : PH_SOI_PAD;
          end else begin
            spur_nxt = 1'b1;
          end
        end
        PH_SOI_PAD, PH_PAD: begin
          if (data_byte != 8'hFF) begin
            marker_nxt = data_byte;
            if (spur_r) begin
              warn = WARN_SPURIOUS;
            end
            spur_nxt = 1'b0;
            if (phase_r == PH_SOI_PAD) begin
              if (data_byte == 8'hD8) begin
                phase_nxt = PH_SEEK;
              end else begin
                ev        = EV_ERR;
                err       = ERR_NO_SOI;
                phase_nxt = PH_IDLE;
              end
            end else if (data_byte == 8'hD9 || data_byte == 8'hDA) begin
              ev        = EV_END;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_LEN_HI;
            end
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = data_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_full[15:1] == 15'd0) begin
            ev        = EV_ERR;
            err       = ERR_SHORT;
            phase_nxt = PH_IDLE;
          end else begin
            decl_nxt = len_full - 16'd2;
            if (sof_cur != PROC_NOT_SOF) begin
              phase_nxt = PH_SOF_P;
            end else begin
              left_nxt = len_full - 16'd2;
              if (marker_r == 8'hE1 || marker_r == 8'hE2) begin
                ev     = EV_APP;
                seglen = len_full - 16'd2;
              end
              if (len_full == 16'd2) begin
                phase_nxt = PH_SEEK;
              end else if (marker_r == 8'hE1 || marker_r == 8'hE2) begin
                phase_nxt = PH_PAYLOAD;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          pbyte    = data_byte;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            ev        = EV_LAST;
            phase_nxt = PH_SEEK;
          end else begin
            ev = EV_BYTE;
          end
        end
        PH_SKIP: begin
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = PH_SEEK;
          end
        end
        PH_SOF_P: begin
          prec_nxt  = data_byte;
          phase_nxt = PH_SOF_H1;
        end
        PH_SOF_H1: begin
          height_nxt = {data_byte, height_r[7:0]};
          phase_nxt  = PH_SOF_H2;
        end
        PH_SOF_H2: begin
          height_nxt = {height_r[15:8], data_byte};
          phase_nxt  = PH_SOF_W1;
        end
        PH_SOF_W1: begin
          width_nxt = {data_byte, width_r[7:0]};
          phase_nxt = PH_SOF_W2;
        end
        PH_SOF_W2: begin
          width_nxt = {width_r[15:8], data_byte};
          phase_nxt = PH_SOF_N;
        end
        PH_SOF_N: begin
          comps_nxt = data_byte;
          proc_nxt  = sof_cur;
          if (decl_r != {5'd0, sof_expect}) begin
            ev        = EV_ERR;
            err       = ERR_FRAMELEN;
            phase_nxt = PH_IDLE;
          end else begin
            ev        = EV_FRAME;
            frame_nxt = 1'b1;
            // Component records are three bytes each and are skipped.
            left_nxt  = {5'd0, sof_expect - 11'd6};
            phase_nxt = (data_byte == 8'd0) ? PH_SEEK : PH_SKIP;
          end
        end
        default: begin
        end
      endcase
    end

    // Running out of file with the parser left anywhere but idle overrides the byte's own event.
    if (last_of_file && phase_nxt != PH_IDLE) begin
      ev        = EV_ERR;
      err       = ERR_EARLY;
      seglen    = 16'd0;
      pbyte     = 8'd0;
      phase_nxt = PH_IDLE;
    end
  end

  always_comb begin
    res.event_res      = ev;
    res.marker         = marker_nxt;
    res.segment_length = seglen;
    res.payload_byte   = pbyte;
    res.error_code     = err;
    res.warning        = warn;
    res.precision      = prec_nxt;
    res.image_height   = height_nxt;
    res.image_width    = width_nxt;
    res.components     = comps_nxt;
    res.process_index  = proc_nxt;
    res.frame_seen     = frame_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      marker_r <= 8'd0;
      len_hi_r <= 8'd0;
      left_r   <= 16'd0;
      decl_r   <= 16'd0;
      spur_r   <= 1'b0;
      prec_r   <= 8'd0;
      height_r <= 16'd0;
      width_r  <= 16'd0;
      comps_r  <= 8'd0;
      proc_r   <= PROC_NONE;
      frame_r  <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      marker_r <= marker_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      decl_r   <= decl_nxt;
      spur_r   <= spur_nxt;
      prec_r   <= prec_nxt;
      height_r <= height_nxt;
      width_r  <= width_nxt;
      comps_r  <= comps_nxt;
      proc_r   <= proc_nxt;
      frame_r  <= frame_nxt;
    end
  end

endmodule

[rtl/jms_out_buf.sv]
// ----------------------------------------------------------------------------
// jms_out_buf
// Two-entry result buffer: an output register plus a skid register, so the
// input side can take one more result after the output stalls.
// ----------------------------------------------------------------------------
module jms_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jms_pkg::jms_result_t in_res,
  output logic                out_valid,
  input  logic                out_ready,
  output jms_pkg::jms_result_t out_res
);
  import jms_pkg::*;

  logic        out_valid_r;
  logic        skid_valid_r;
  jms_result_t out_res_r;
  jms_result_t skid_res_r;
  logic        push;

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (push) begin
        out_res_r <= in_res;
      end
    end else if (push) begin
      skid_res_r <= in_res;
    end
  end

endmodule

[rtl/jpeg_marker_scanner.sv]
// ----------------------------------------------------------------------------
// jpeg_marker_scanner
// Byte-stream JPEG marker parser with frame header capture and APP1/APP2
// payload pass-through.
// ----------------------------------------------------------------------------
// The scanner takes one file byte per cycle while its output buffer has room
// and returns exactly one result item per byte through its output register.
// The marker state update is combinational, and a two-entry output buffer
// lets one more byte be taken once the result side stalls. Assert in_tuser
// for the first byte of a file and in_tlast for its last; bytes outside a
// file produce event 0. Frame header fields on the output hold the last
// captured frame and survive a new file.
module jpeg_marker_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] first_of_file
  input  logic        in_tlast,   // last_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] marker, [23:8] segment_length, [31:24] payload_byte,
  // [34:32] error_code, [36:35] warning, [44:37] precision,
  // [60:45] image_height, [76:61] image_width, [84:77] components,
  // [88:85] process_index, [89] frame_seen, [95:90] zero
  output logic [jms_pkg::TDATA_OUT_W-1:0] out_tdata,
  output logic [2:0]  out_tuser   // [2:0] event_res
);
  import jms_pkg::*;

  logic        accept;
  jms_result_t res;
  jms_result_t res_q;

  assign accept = in_tvalid && in_tready;

  jms_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_tdata),
    .first_of_file (in_tuser[0]),
    .last_of_file  (in_tlast),
    .res           (res)
  );

  jms_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_res    (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res_q)
  );

  assign out_tuser = res_q.event_res;
  assign out_tdata = {6'd0, res_q.frame_seen, res_q.process_index, res_q.components,
                      res_q.image_width, res_q.image_height, res_q.precision,
                      res_q.warning, res_q.error_code, res_q.payload_byte,
                      res_q.segment_length, res_q.marker};

endmodule

[rtl/jms_checker.sv]
// ----------------------------------------------------------------------------
// jms_checker
// Port-level checks of the JPEG marker scanner, bound to the top level.
// ----------------------------------------------------------------------------
module jms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic [0:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [jms_pkg::TDATA_OUT_W-1:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import jms_pkg::*;

  logic [2:0] err_code;
  logic [3:0] proc_idx;
  logic       frame_seen;

  assign err_code   = out_tdata[34:32];
  assign proc_idx   = out_tdata[88:85];
  assign frame_seen = out_tdata[89];

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // An error event always carries a reason, and only an error event does.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == EV_ERR) == (err_code != ERR_NONE)))
    else $error("error code and event disagree");

  // A captured frame shows a valid process index and the frame flag.
  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_FRAME |-> frame_seen && proc_idx < PROC_NONE)
    else $error("frame event without frame data");

  // Payload bytes only ever appear with payload events.
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_BYTE && out_tuser != EV_LAST
      |-> out_tdata[31:24] == 8'd0)
    else $error("payload byte outside payload event");

endmodule

bind jpeg_marker_scanner jms_checker u_jms_checker (.*);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JPEG marker scanner. Byte streams go in on the
// input stream: a short table of hand-made files, then random files that are
// mostly well-formed with random content plus some noise. An in-bench model
// of the parser predicts one result item per byte, and every result that
// leaves the block is checked against it in order, under four settings of
// source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jms_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;

  localparam logic [7:0] BYTE_FILL   = 8'hFF;
  localparam logic [7:0] MK_SOI      = 8'hD8;
  localparam logic [7:0] MK_EOI      = 8'hD9;
  localparam logic [7:0] MK_SOS      = 8'hDA;
  localparam logic [7:0] MK_APP1     = 8'hE1;
  localparam logic [7:0] MK_APP2     = 8'hE2;
  localparam logic [7:0] MK_SOF_BASE = 8'hC0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOP2, ST_SOI_SEEK, ST_SOI_PAD, ST_SEEK, ST_PAD, ST_LEN_HI,
    ST_LEN_LO, ST_PAYLOAD, ST_SKIP, ST_SOF_P, ST_SOF_H1, ST_SOF_H2,
    ST_SOF_W1, ST_SOF_W2, ST_SOF_N
  } parse_state_t;

  typedef struct packed {
    jms_event_t  ev;
    logic [7:0]  marker;
    logic [15:0] seg_len;
    logic [7:0]  pay;
    logic [2:0]  err;
    logic [1:0]  warn;
    logic [7:0]  prec;
    logic [15:0] height;
    logic [15:0] width;
    logic [7:0]  comps;
    logic [3:0]  proc;
    logic        seen;
    logic [5:0]  spare;
  } scan_result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       pinned;
    jms_event_t ev;
    logic [2:0] err;
    logic [1:0] warn;
  } byte_row_t;

  // Hand-made files. Rows with pinned set carry the event, error and warning
  // that the byte must produce; the rest of each result comes from the model.
  localparam byte_row_t DIRECTED [37] = '{
    '{8'h00, 1'b0, 1'b0, 1'b1, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h5A, 1'b1, 1'b0, 1'b1, EV_NONE,  ERR_NONE,     WARN_NO_SOI},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hC0, 1'b0, 1'b0, 1'b1, EV_ERR,   ERR_NO_SOI,   WARN_NONE},
    '{8'hFF, 1'b1, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b1, EV_NONE,  ERR_NONE,     WARN_NO_SOI},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hD8, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h33, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hC2, 1'b0, 1'b0, 1'b1, EV_NONE,  ERR_NONE,     WARN_SPURIOUS},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h08, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b1, EV_FRAME, ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hE2, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h03, 1'b0, 1'b0, 1'b1, EV_APP,   ERR_NONE,     WARN_NONE},
    '{8'h80, 1'b0, 1'b0, 1'b1, EV_LAST,  ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hE1, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b1, EV_ERR,   ERR_SHORT,    WARN_NONE},
    '{8'hFF, 1'b1, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hD8, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hD9, 1'b0, 1'b0, 1'b1, EV_END,   ERR_NONE,     WARN_NONE},
    '{8'hFF, 1'b1, 1'b0, 1'b0, EV_NONE,  ERR_NONE,     WARN_NONE},
    '{8'hD8, 1'b0, 1'b1, 1'b1, EV_ERR,   ERR_EARLY,    WARN_NONE},
    '{8'hFF, 1'b1, 1'b1, 1'b1, EV_ERR,   ERR_EARLY,    WARN_NONE},
    '{8'h00, 1'b0, 1'b1, 1'b1, EV_NONE,  ERR_NONE,     WARN_NONE}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic [0:0]             in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [TDATA_OUT_W-1:0] out_tdata;
  logic [2:0]             out_tuser;

  // Parser model state.
  parse_state_t st;
  logic [7:0]   seg_marker;
  logic [7:0]   len_msb;
  logic [15:0]  body_left;
  logic [15:0]  body_len;
  logic         junk_seen;
  logic [7:0]   fr_prec;
  logic [15:0]  fr_height;
  logic [15:0]  fr_width;
  logic [7:0]   fr_comps;
  logic [3:0]   fr_proc;
  logic         fr_seen;

  scan_result_t pending_results[$];
  logic [7:0]   file_bytes[$];
  bit           file_noise;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  files_sent = 0;
  int unsigned  fail_count = 0;
  int unsigned  event_tally [8];

  jpeg_marker_scanner i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // Process index of a frame marker, or PROC_NOT_SOF.
  function automatic logic [3:0] frame_kind(input logic [7:0] m);
    logic [3:0] lo;
    lo = m[3:0];
    if (m[7:4] != MK_SOF_BASE[7:4] || lo == 4'd4 || lo == 4'd8 || lo == 4'd12)
      return PROC_NOT_SOF;
    return lo - {3'd0, lo > 4'd4} - {3'd0, lo > 4'd8} - {3'd0, lo > 4'd12};
  endfunction

  task automatic reset_parser();
    st = ST_IDLE;
    seg_marker = '0;
    len_msb = '0;
    body_left = '0;
    body_len = '0;
    junk_seen = 1'b0;
    fr_prec = '0;
    fr_height = '0;
    fr_width = '0;
    fr_comps = '0;
    fr_proc = PROC_NONE;
    fr_seen = 1'b0;
  endtask

  // Advances the parser model by one byte and returns the result it causes.
  function automatic scan_result_t scan_byte(input logic [7:0] b, input logic first,
                                             input logic last);
    scan_result_t r;
    logic [15:0]  len;
    r = '0;
    r.ev = EV_NONE;
    if (first) begin
      junk_seen = 1'b0;
      if (b == BYTE_FILL) begin
        st = ST_TOP2;
      end else begin
        r.warn = WARN_NO_SOI;
        st = ST_SOI_SEEK;
      end
    end else begin
      case (st)
        ST_TOP2: begin
          if (b == MK_SOI) begin
            st = ST_SEEK;
          end else begin
            r.warn = WARN_NO_SOI;
            st = ST_SOI_SEEK;
          end
        end
        ST_SOI_SEEK, ST_SEEK: begin
          if (b == BYTE_FILL) st = (st == ST_SEEK) ? ST_PAD : ST_SOI_PAD;
          else junk_seen = 1'b1;
        end
        ST_SOI_PAD, ST_PAD: begin
          if (b != BYTE_FILL) begin
            seg_marker = b;
            if (junk_seen) r.warn = WARN_SPURIOUS;
            junk_seen = 1'b0;
            if (st == ST_SOI_PAD) begin
              if (b == MK_SOI) begin
                st = ST_SEEK;
              end else begin
                r.ev = EV_ERR;
                r.err = ERR_NO_SOI;
                st = ST_IDLE;
              end
            end else if (b == MK_EOI || b == MK_SOS) begin
              r.ev = EV_END;
              st = ST_IDLE;
            end else begin
              st = ST_LEN_HI;
            end
          end
        end
        ST_LEN_HI: begin
          len_msb = b;
          st = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          len = {len_msb, b};
          if (len < 16'd2) begin
            r.ev = EV_ERR;
            r.err = ERR_SHORT;
            st = ST_IDLE;
          end else begin
            body_len = len - 16'd2;
            if (frame_kind(seg_marker) != PROC_NOT_SOF) begin
              st = ST_SOF_P;
            end else begin
              if (seg_marker == MK_APP1 || seg_marker == MK_APP2) begin
                r.ev = EV_APP;
                r.seg_len = body_len;
              end
              body_left = body_len;
              if (body_left == 16'd0) st = ST_SEEK;
              else st = (r.ev == EV_APP) ? ST_PAYLOAD : ST_SKIP;
            end
          end
        end
        ST_PAYLOAD: begin
          r.pay = b;
          body_left = body_left - 16'd1;
          if (body_left == 16'd0) begin
            r.ev = EV_LAST;
            st = ST_SEEK;
          end else begin
            r.ev = EV_BYTE;
          end
        end
        ST_SKIP: begin
          body_left = body_left - 16'd1;
          if (body_left == 16'd0) st = ST_SEEK;
        end
        ST_SOF_P: begin
          fr_prec = b;
          st = ST_SOF_H1;
        end
        ST_SOF_H1: begin
          fr_height[15:8] = b;
          st = ST_SOF_H2;
        end
        ST_SOF_H2: begin
          fr_height[7:0] = b;
          st = ST_SOF_W1;
        end
        ST_SOF_W1: begin
          fr_width[15:8] = b;
          st = ST_SOF_W2;
        end
        ST_SOF_W2: begin
          fr_width[7:0] = b;
          st = ST_SOF_N;
        end
        ST_SOF_N: begin
          fr_comps = b;
          fr_proc = frame_kind(seg_marker);
          if (int'(body_len) != 6 + 3 * int'(b)) begin
            r.ev = EV_ERR;
            r.err = ERR_FRAMELEN;
            st = ST_IDLE;
          end else begin
            r.ev = EV_FRAME;
            fr_seen = 1'b1;
            body_left = 16'(3 * int'(b));
            st = (body_left == 16'd0) ? ST_SEEK : ST_SKIP;
          end
        end
        default: ;
      endcase
    end
    // A final byte that leaves a structure open overrides whatever it caused.
    if (last && st != ST_IDLE) begin
      r.ev = EV_ERR;
      r.err = ERR_EARLY;
      r.seg_len = '0;
      r.pay = '0;
      st = ST_IDLE;
    end
    r.marker = seg_marker;
    r.prec = fr_prec;
    r.height = fr_height;
    r.width = fr_width;
    r.comps = fr_comps;
    r.proc = fr_proc;
    r.seen = fr_seen;
    return r;
  endfunction

  function automatic string fmt(input scan_result_t r);
    return $sformatf({"ev=%0d mk=%02h len=%0d pay=%02h err=%0d warn=%0d prec=%0d",
                      " h=%0d w=%0d n=%0d proc=%0d seen=%0d spare=%0h"},
                     r.ev, r.marker, r.seg_len, r.pay, r.err, r.warn, r.prec,
                     r.height, r.width, r.comps, r.proc, r.seen, r.spare);
  endfunction

  // Offers one byte, waits for the handshake and queues the predicted result.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic pinned, input jms_event_t ev,
                           input logic [2:0] err, input logic [1:0] warn);
    scan_result_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= first;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    r = scan_byte(b, first, last);
    if (pinned) begin
      r.ev = ev;
      r.err = err;
      r.warn = warn;
    end
    pending_results.push_back(r);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic add_random(input int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_junk();
    repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom_range(0, 254)));
  endtask

  task automatic add_len(input int n);
    file_bytes.push_back(8'(n >> 8));
    file_bytes.push_back(8'(n));
  endtask

  // Builds one file: mostly a well-formed marker sequence with random content,
  // sometimes with a bad start, bad lengths, truncation or plain noise.
  task automatic build_file();
    int         n;
    int         c;
    int         lo;
    logic [7:0] m;
    file_bytes.delete();
    file_noise = ($urandom_range(0, 9) == 0);
    if (file_noise) begin
      add_random($urandom_range(1, 16));
      return;
    end
    case ($urandom_range(0, 19))
      0: begin
        file_bytes.push_back(8'($urandom_range(0, 254)));
        if ($urandom_range(0, 1) == 1) add_junk();
        file_bytes.push_back(BYTE_FILL);
        // The first marker of the search must be SOI; now and then it is not.
        file_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254))
                                                         : MK_SOI);
      end
      1: begin
        file_bytes.push_back(BYTE_FILL);
        do m = 8'($urandom_range(0, 255)); while (m == MK_SOI);
        file_bytes.push_back(m);
        file_bytes.push_back(BYTE_FILL);
        file_bytes.push_back(MK_SOI);
      end
      default: begin
        file_bytes.push_back(BYTE_FILL);
        file_bytes.push_back(MK_SOI);
      end
    endcase
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 7) == 0) add_junk();
      file_bytes.push_back(BYTE_FILL);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) file_bytes.push_back(BYTE_FILL);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          file_bytes.push_back(($urandom_range(0, 1) == 1) ? MK_APP2 : MK_APP1);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
          add_len(n + 2);
          add_random(n);
        end
        3, 4: begin
          do lo = $urandom_range(0, 15); while (lo == 4 || lo == 8 || lo == 12);
          file_bytes.push_back(MK_SOF_BASE | 8'(lo));
          c = $urandom_range(0, 4);
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
          add_len(8 + 3 * c + n);
          add_random(5);
          file_bytes.push_back(8'(c));
          add_random(3 * c);
        end
        9: begin
          file_bytes.push_back(MK_APP1);
          add_len($urandom_range(0, 1));
        end
        default: begin
          do m = 8'($urandom_range(0, 254));
          while (m == MK_EOI || m == MK_SOS || m == MK_APP1 || m == MK_APP2 ||
                 frame_kind(m) != PROC_NOT_SOF);
          file_bytes.push_back(m);
          n = $urandom_range(0, 10);
          add_len(n + 2);
          add_random(n);
        end
      endcase
    end
    file_bytes.push_back(BYTE_FILL);
    file_bytes.push_back(($urandom_range(0, 1) == 1) ? MK_SOS : MK_EOI);
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, file_bytes.size());
      file_bytes = file_bytes[0:n-1];
    end else if ($urandom_range(0, 9) == 0) begin
      add_random($urandom_range(1, 3));
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ev = jms_event_t'(out_tuser);
      got.marker = out_tdata[7:0];
      got.seg_len = out_tdata[23:8];
      got.pay = out_tdata[31:24];
      got.err = out_tdata[34:32];
      got.warn = out_tdata[36:35];
      got.prec = out_tdata[44:37];
      got.height = out_tdata[60:45];
      got.width = out_tdata[76:61];
      got.comps = out_tdata[84:77];
      got.proc = out_tdata[88:85];
      got.seen = out_tdata[89];
      got.spare = out_tdata[95:90];
      event_tally[out_tuser]++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: %s", fmt(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result mismatch at %0t\n  expected %s\n  actual   %s",
                     $realtime, fmt(want), fmt(got));
          end
        end
      end
    end
  end

  initial begin
    int unsigned drain;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    reset_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].b, DIRECTED[i].first, DIRECTED[i].last,
                DIRECTED[i].pinned, DIRECTED[i].ev, DIRECTED[i].err, DIRECTED[i].warn);
    end
    files_sent = 7;

    while (bytes_sent < $size(DIRECTED) + RANDOM_ITEMS) begin
      // Four quarters: no idling, idle source, stalling sink, both.
      case (((bytes_sent - $size(DIRECTED)) * 4) / RANDOM_ITEMS)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      build_file();
      foreach (file_bytes[i]) begin
        send_byte(file_bytes[i],
                  i == 0 || (file_noise && $urandom_range(0, 7) == 0),
                  i == file_bytes.size() - 1 || (file_noise && $urandom_range(0, 7) == 0),
                  1'b0, EV_NONE, ERR_NONE, WARN_NONE);
      end
      files_sent++;
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end

    $display("covered %0d bytes in %0d files, directed and random, under four idling mixes",
             bytes_sent, files_sent);
    $display("seen: %0d app segments, %0d payload bytes, %0d frames, %0d scan ends, %0d errors",
             event_tally[EV_APP], event_tally[EV_BYTE] + event_tally[EV_LAST],
             event_tally[EV_FRAME], event_tally[EV_END], event_tally[EV_ERR]);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout waiting for the scanner");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
